### hdl/xcpd_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcpd_pkg
// Shared widths, result kind codes and register indexes for the deframer.
// ---------------------------------------------------------------------------
package xcpd_pkg;

  localparam int BYTE_W            = 8;
  localparam int KIND_W            = 3;
  localparam int TIMEOUT_W         = 16;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 16;
  localparam int TICK_COUNT_W_DEF  = 16;

  // result kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_DATA    = 3'd0,
    KIND_GOOD    = 3'd1,
    KIND_BAD     = 3'd2,
    KIND_PROT    = 3'd3,
    KIND_TIMEOUT = 3'd4
  } kind_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_MARKER  = 2'd0,
    REG_MAX_PAYLOAD   = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } cfg_reg_t;

  localparam logic [BYTE_W-1:0]    START_MARKER_RST  = 8'd0;
  localparam logic [BYTE_W-1:0]    MAX_PAYLOAD_RST   = 8'd255;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_TICKS_RST = 16'd500;

endpackage

### hdl/xcpd_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xcpd stream interfaces
// Valid/ready channels for link beats in and deframer results out.
// ---------------------------------------------------------------------------
interface xcpd_in_if;
  import xcpd_pkg::*;

  logic              valid;
  logic              ready;
  logic              mode;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output mode, output rx_byte, input ready);
  modport sink   (input valid, input mode, input rx_byte, output ready);
endinterface

interface xcpd_out_if;
  import xcpd_pkg::*;

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [BYTE_W-1:0] payload_length;

  modport source (output valid, output kind, output payload_byte, output payload_length,
                  input ready);
  modport sink   (input valid, input kind, input payload_byte, input payload_length,
                  output ready);
endinterface

### hdl/xor_checked_packet_deframer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xor_checked_packet_deframer
// Length-prefixed packet receiver with XOR checksum and idle timeout.
// ---------------------------------------------------------------------------
// usage
//   in_if  : one beat per received link byte (mode 0) or idle tick (mode 1)
//   out_if : zero or one result beat per input beat: payload byte, packet
//            good, checksum bad, protocol error or timeout
//   cfg_*  : start marker, max payload length and timeout ticks; write only
//            while no beat is in flight
// timing
//   a beat is captured in the input register, then the framing state and
//   the result register are updated from it once the result register is
//   free or being drained
//   one beat per cycle sustained while out_if.ready stays high
// reset
//   rst_n low: hunting for a start byte, counters and checksum cleared,
//   registers back to their defaults, both registers empty
// stalls
//   when out_if.ready is low and a result is held, the input register keeps
//   its beat and in_if.ready drops once that register is full too
// ---------------------------------------------------------------------------
module xor_checked_packet_deframer #(
  parameter int TICK_COUNT_WIDTH = xcpd_pkg::TICK_COUNT_W_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  xcpd_in_if.sink                       in_if,
  xcpd_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [xcpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [xcpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import xcpd_pkg::*;

  // compare width covers both the idle counter and the timeout register
  localparam int CMP_W = (TICK_COUNT_WIDTH > TIMEOUT_W) ? TICK_COUNT_WIDTH : TIMEOUT_W;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

  // configuration
  logic [BYTE_W-1:0]    start_marker_r;
  logic [BYTE_W-1:0]    max_payload_r;
  logic [TIMEOUT_W-1:0] timeout_ticks_r;

  // input register
  logic              in_vld_r;
  logic              in_mode_r;
  logic [BYTE_W-1:0] in_byte_r;

  // framing state
  phase_t                      phase_r, phase_nxt;
  logic [BYTE_W-1:0]           bytes_left_r, bytes_left_nxt;
  logic [BYTE_W-1:0]           xor_r, xor_nxt;
  logic [TICK_COUNT_WIDTH-1:0] idle_cnt_r, idle_cnt_nxt;
  logic [BYTE_W-1:0]           len_seen_r, len_seen_nxt;

  // result register
  logic              out_vld_r, out_vld_nxt;
  kind_t             out_kind_r, out_kind_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [BYTE_W-1:0] out_len_r, out_len_nxt;

  logic                        advance;
  logic [TICK_COUNT_WIDTH-1:0] idle_inc;
  logic [BYTE_W-1:0]           left_dec;

  // the held beat moves on when the result register is free or being drained
  assign advance     = in_vld_r && (!out_vld_r || out_if.ready);
  assign in_if.ready = !in_vld_r || advance;

  // saturating idle count
  assign idle_inc = (idle_cnt_r == {TICK_COUNT_WIDTH{1'b1}}) ? idle_cnt_r
                                                             : idle_cnt_r + 1'b1;
  assign left_dec = bytes_left_r - 8'd1;

  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    xor_nxt        = xor_r;
    idle_cnt_nxt   = idle_cnt_r;
    len_seen_nxt   = len_seen_r;
    out_kind_nxt   = out_kind_r;
    out_byte_nxt   = out_byte_r;
    out_len_nxt    = out_len_r;
    out_vld_nxt    = out_vld_r && !out_if.ready;

    if (advance) begin
      out_vld_nxt  = 1'b0;
      out_byte_nxt = '0;
      out_len_nxt  = '0;
      if (in_mode_r) begin
        // idle tick
        idle_cnt_nxt = idle_inc;
        if (CMP_W'(idle_inc) >= CMP_W'(timeout_ticks_r)) begin
          idle_cnt_nxt   = '0;
          phase_nxt      = PH_HUNT;
          bytes_left_nxt = '0;
          xor_nxt        = '0;
          out_vld_nxt    = 1'b1;
          out_kind_nxt   = KIND_TIMEOUT;
          out_len_nxt    = (phase_r == PH_DATA || phase_r == PH_SUM) ? len_seen_r : '0;
        end
      end else begin
        idle_cnt_nxt = '0;
        case (phase_r)
          PH_HUNT: begin
            if (in_byte_r == start_marker_r) begin
              phase_nxt      = PH_LEN;
              xor_nxt        = '0;
              bytes_left_nxt = '0;
              len_seen_nxt   = '0;
            end else begin
              out_vld_nxt  = 1'b1;
              out_kind_nxt = KIND_PROT;
            end
          end
          PH_LEN: begin
            if (in_byte_r > max_payload_r) begin
              // oversize length is reported back with the error
              phase_nxt      = PH_HUNT;
              bytes_left_nxt = '0;
              xor_nxt        = '0;
              out_vld_nxt    = 1'b1;
              out_kind_nxt   = KIND_PROT;
              out_len_nxt    = in_byte_r;
            end else begin
              len_seen_nxt   = in_byte_r;
              bytes_left_nxt = in_byte_r;
              xor_nxt        = in_byte_r;
              // empty packet goes straight to its checksum
              phase_nxt      = (in_byte_r == '0) ? PH_SUM : PH_DATA;
            end
          end
          PH_DATA: begin
            xor_nxt        = xor_r ^ in_byte_r;
            bytes_left_nxt = left_dec;
            if (left_dec == '0) begin
              phase_nxt = PH_SUM;
            end
            out_vld_nxt  = 1'b1;
            out_kind_nxt = KIND_DATA;
            out_byte_nxt = in_byte_r;
            out_len_nxt  = len_seen_r;
          end
          PH_SUM: begin
            phase_nxt      = PH_HUNT;
            bytes_left_nxt = '0;
            xor_nxt        = '0;
            out_vld_nxt    = 1'b1;
            out_kind_nxt   = (in_byte_r == xor_r) ? KIND_GOOD : KIND_BAD;
            out_len_nxt    = len_seen_r;
          end
          default: begin
            phase_nxt = PH_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r  <= START_MARKER_RST;
      max_payload_r   <= MAX_PAYLOAD_RST;
      timeout_ticks_r <= TIMEOUT_TICKS_RST;
      in_vld_r        <= 1'b0;
      phase_r         <= PH_HUNT;
      bytes_left_r    <= '0;
      xor_r           <= '0;
      idle_cnt_r      <= '0;
      len_seen_r      <= '0;
      out_vld_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_START_MARKER:  start_marker_r  <= cfg_wdata[BYTE_W-1:0];
          REG_MAX_PAYLOAD:   max_payload_r   <= cfg_wdata[BYTE_W-1:0];
          REG_TIMEOUT_TICKS: timeout_ticks_r <= cfg_wdata[TIMEOUT_W-1:0];
          default: ;
        endcase
      end
      if (in_if.valid && in_if.ready) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      xor_r        <= xor_nxt;
      idle_cnt_r   <= idle_cnt_nxt;
      len_seen_r   <= len_seen_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // beat payloads, no reset needed
  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_mode_r <= in_if.mode;
      in_byte_r <= in_if.rx_byte;
    end
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_if.valid          = out_vld_r;
  assign out_if.kind           = out_kind_r;
  assign out_if.payload_byte   = out_byte_r;
  assign out_if.payload_length = out_len_r;

endmodule

### tb/sv/xor_checked_packet_deframer_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// xor_checked_packet_deframer_tb
// Self-checking bench for the deframer: directed framing cases, then
// randomized packet traffic over several register settings. A scoreboard
// class tracks framing state on every accepted beat and checks each result.
// ---------------------------------------------------------------------------
module xor_checked_packet_deframer_tb;
  import xcpd_pkg::*;

  // one expected result beat
  typedef struct {
    kind_t             kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] payload_length;
  } frame_result_t;

  // framing phases as the scoreboard sees them
  typedef enum logic [1:0] {
    PH_HUNT,
    PH_LENGTH,
    PH_PAYLOAD,
    PH_CHECKSUM
  } frame_phase_t;

  // tracks the deframer state and the results still owed by the block
  class frame_tracker;
    logic [BYTE_W-1:0]           start_marker;
    logic [BYTE_W-1:0]           max_payload;
    logic [TIMEOUT_W-1:0]        timeout_ticks;
    frame_phase_t                phase;
    logic [BYTE_W-1:0]           bytes_left;
    logic [BYTE_W-1:0]           running_xor;
    logic [BYTE_W-1:0]           length_seen;
    logic [TICK_COUNT_W_DEF-1:0] idle_count;
    frame_result_t               pending_results[$];
    int                          fail_count;
    int                          results_seen;
    int                          good_packets;
    int                          bad_packets;
    int                          proto_errors;
    int                          timeouts;

    function new();
      start_marker  = START_MARKER_RST;
      max_payload   = MAX_PAYLOAD_RST;
      timeout_ticks = TIMEOUT_TICKS_RST;
      idle_count    = '0;
      length_seen   = '0;
      back_to_hunt();
    endfunction

    function void back_to_hunt();
      phase       = PH_HUNT;
      bytes_left  = '0;
      running_xor = '0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_START_MARKER:  start_marker  = value[BYTE_W-1:0];
        REG_MAX_PAYLOAD:   max_payload   = value[BYTE_W-1:0];
        REG_TIMEOUT_TICKS: timeout_ticks = value[TIMEOUT_W-1:0];
        default: ;
      endcase
    endfunction

    function void owe(kind_t kind, logic [BYTE_W-1:0] data, logic [BYTE_W-1:0] len);
      frame_result_t r;
      r.kind           = kind;
      r.payload_byte   = data;
      r.payload_length = len;
      pending_results.push_back(r);
    endfunction

    // advance the framing state by one accepted beat
    function void take_beat(logic mode, logic [BYTE_W-1:0] b);
      if (mode) begin
        if (idle_count != '1) begin
          idle_count++;
        end
        if (idle_count >= timeout_ticks) begin
          owe(KIND_TIMEOUT, '0,
              (phase == PH_PAYLOAD || phase == PH_CHECKSUM) ? length_seen : '0);
          idle_count = '0;
          back_to_hunt();
        end
        return;
      end
      idle_count = '0;
      case (phase)
        PH_HUNT: begin
          if (b == start_marker) begin
            phase       = PH_LENGTH;
            running_xor = '0;
            bytes_left  = '0;
            length_seen = '0;
          end else begin
            owe(KIND_PROT, '0, '0);
          end
        end
        PH_LENGTH: begin
          if (b > max_payload) begin
            back_to_hunt();
            owe(KIND_PROT, '0, b);
          end else begin
            length_seen = b;
            bytes_left  = b;
            running_xor = b;
            phase       = (b == '0) ? PH_CHECKSUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          running_xor = running_xor ^ b;
          bytes_left  = bytes_left - 1'b1;
          if (bytes_left == '0) begin
            phase = PH_CHECKSUM;
          end
          owe(KIND_DATA, b, length_seen);
        end
        default: begin
          owe((b == running_xor) ? KIND_GOOD : KIND_BAD, '0, length_seen);
          back_to_hunt();
        end
      endcase
    endfunction

    function void match_result(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                               logic [BYTE_W-1:0] len);
      frame_result_t e;
      if (pending_results.size() == 0) begin
        $error("unexpected result: kind %0d byte %0d length %0d", kind, data, len);
        fail_count++;
        return;
      end
      e = pending_results.pop_front();
      results_seen++;
      if (kind !== e.kind) begin
        $error("kind mismatch: expected %0d, got %0d", e.kind, kind);
        fail_count++;
      end
      if (data !== e.payload_byte) begin
        $error("payload_byte mismatch: expected %0d, got %0d", e.payload_byte, data);
        fail_count++;
      end
      if (len !== e.payload_length) begin
        $error("payload_length mismatch: expected %0d, got %0d", e.payload_length, len);
        fail_count++;
      end
      case (e.kind)
        KIND_GOOD:    good_packets++;
        KIND_BAD:     bad_packets++;
        KIND_PROT:    proto_errors++;
        KIND_TIMEOUT: timeouts++;
        default: ;
      endcase
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  xcpd_in_if  in_if ();
  xcpd_out_if out_if ();

  frame_tracker tracker;
  bit           calm;        // no random gaps or stalls while set
  int           beats_sent;

  xor_checked_packet_deframer #(
    .TICK_COUNT_WIDTH(TICK_COUNT_W_DEF)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // driving tasks
  // -------------------------------------------------------------------------

  // one beat on the link channel; valid stays high into the next beat when
  // no gap is drawn, so it is never dropped and raised in the same step
  task automatic send_beat(input logic mode, input logic [BYTE_W-1:0] b);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.rx_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.take_beat(mode, b);
    beats_sent++;
  endtask

  task automatic send_byte(input logic [BYTE_W-1:0] b);
    send_beat(1'b0, b);
  endtask

  // idle ticks carry junk in rx_byte, the block must ignore it
  task automatic send_idle(input int n);
    repeat (n) send_beat(1'b1, 8'($urandom));
  endtask

  // start, length, random payload, checksum (optionally corrupted);
  // now and then an idle tick or three lands mid packet
  task automatic send_packet(input int len, input bit bad_sum);
    logic [BYTE_W-1:0] sum;
    logic [BYTE_W-1:0] b;
    send_byte(tracker.start_marker);
    send_byte(len[BYTE_W-1:0]);
    sum = len[BYTE_W-1:0];
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if ($urandom_range(0, 19) == 0) begin
        send_idle($urandom_range(1, 3));
      end
      send_byte(b);
      sum = sum ^ b;
    end
    if (bad_sum) begin
      sum = sum ^ 8'($urandom_range(1, 255));
    end
    send_byte(sum);
  endtask

  // all three registers back to back, then the scoreboard copy
  task automatic program_regs(input logic [BYTE_W-1:0] marker,
                              input logic [BYTE_W-1:0] max_len,
                              input logic [TIMEOUT_W-1:0] ticks);
    cfg_we    <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_wdata <= CFG_DATA_W'(marker);
    @(posedge clk);
    cfg_index <= REG_MAX_PAYLOAD;
    cfg_wdata <= CFG_DATA_W'(max_len);
    @(posedge clk);
    cfg_index <= REG_TIMEOUT_TICKS;
    cfg_wdata <= CFG_DATA_W'(ticks);
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(REG_START_MARKER, CFG_DATA_W'(marker));
    tracker.write_reg(REG_MAX_PAYLOAD, CFG_DATA_W'(max_len));
    tracker.write_reg(REG_TIMEOUT_TICKS, CFG_DATA_W'(ticks));
  endtask

  // drain: every owed result in, then a wait for a beat that owes
  // nothing but may still sit in the input register
  task automatic settle();
    in_if.valid <= 1'b0;
    for (int w = 0; w < 4000 && tracker.pending_results.size() != 0; w++) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
  endtask

  // mostly well-formed packets with random content, plus oversize lengths,
  // stray bytes and idle runs; idle counts build across runs between bytes
  task automatic random_traffic(input int n);
    int target;
    int pick;
    int maxp;
    int top_len;
    int len;
    target = beats_sent + n;
    while (beats_sent < target) begin
      pick    = $urandom_range(0, 99);
      maxp    = tracker.max_payload;
      top_len = (maxp < 12) ? maxp : 12;
      if (pick < 70) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, maxp)
                                           : $urandom_range(0, top_len);
        send_packet(len, $urandom_range(0, 4) == 0);
      end else if (pick < 80 && maxp < 255) begin
        send_byte(tracker.start_marker);
        send_byte(8'($urandom_range(maxp + 1, 255)));
      end else if (pick < 92) begin
        send_byte(8'($urandom));
      end else if (tracker.timeout_ticks <= 64 && $urandom_range(0, 1) == 0) begin
        send_idle(tracker.timeout_ticks);
      end else begin
        send_idle($urandom_range(1, 6));
      end
    end
  endtask

  // -------------------------------------------------------------------------
  // result side: ready stalls of random length, drawn per beat
  // -------------------------------------------------------------------------
  initial begin
    int stall;
    out_if.ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
    end
  end

  // monitor: every result handshake goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      tracker.match_result(out_if.kind, out_if.payload_byte, out_if.payload_length);
    end
  end

  // -------------------------------------------------------------------------
  // main sequence
  // -------------------------------------------------------------------------
  initial begin
    tracker       = new();
    calm          = 1'b0;
    beats_sent    = 0;
    rst_n         <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_index     <= REG_START_MARKER;
    cfg_wdata     <= '0;
    in_if.valid   <= 1'b0;
    in_if.mode    <= 1'b0;
    in_if.rx_byte <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed framing cases: marker a5, payload up to 8, timeout 3 ticks
    program_regs(8'hA5, 8'd8, 16'd3);
    send_byte(8'hFF);                       // stray byte while hunting
    send_byte(8'hA5);                       // zero length, checksum 0: good
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'hA5);                       // one byte, checksum off: bad
    send_byte(8'h01);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hA5);                       // length one over the max
    send_byte(8'h09);
    send_packet(8, 1'b0);                   // length exactly at the max
    send_idle(3);                           // timeout while hunting
    send_byte(8'hA5);                       // timeout mid payload keeps length
    send_byte(8'h02);
    send_byte(8'h7F);
    send_idle(3);

    // zero timeout fires on the first tick; zero max rejects any length but zero
    settle();
    program_regs(8'h00, 8'h00, 16'd0);
    send_idle(1);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h00);
    send_byte(8'h01);

    // random traffic over several settings, extremes first
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0:       program_regs(8'h00, 8'hFF, 16'd1);
        1:       program_regs(8'hFF, 8'h00, 16'd2);
        5:       program_regs(8'($urandom), 8'hFF, TIMEOUT_TICKS_RST);
        default: program_regs(8'($urandom), 8'($urandom), 16'($urandom_range(1, 40)));
      endcase
      calm = (p != 2) && ($urandom_range(0, 3) == 0);
      random_traffic(110);
    end

    // largest timeout: an idle run mid payload stays well short of it, no gaps
    settle();
    program_regs(8'h5A, 8'hFF, 16'hFFFF);
    calm = 1'b1;
    send_byte(8'h5A);
    send_byte(8'h04);
    send_byte(8'($urandom));
    send_byte(8'($urandom));
    send_idle(40);
    send_packet(3, 1'b0);
    calm = 1'b0;

    settle();
    if (tracker.pending_results.size() != 0) begin
      $error("%0d results never arrived", tracker.pending_results.size());
      tracker.fail_count++;
    end

    $display("covered %0d link beats and %0d result beats over 9 register settings",
             beats_sent, tracker.results_seen);
    $display("good %0d, bad checksum %0d, protocol error %0d, timeout %0d",
             tracker.good_packets, tracker.bad_packets, tracker.proto_errors,
             tracker.timeouts);
    if (tracker.fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hang guard, well past the slowest legal run
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
